### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the UTF-8 stream validator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is high
`define USV_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, ignored while reset is high
`define USV_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

### rtl/core/usv_pkg.sv
// Constants and types for the UTF-8 stream validator.
package usv_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned CP_W   = 21;

   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [CP_W-1:0]   cp_type;
   typedef logic [1:0]        count_type;

   // Lead byte ranges
   localparam byte_type ASCII_MAX  = 8'h7F;
   localparam byte_type LEAD2_MIN  = 8'hC2;
   localparam byte_type LEAD2_MAX  = 8'hDF;
   localparam byte_type LEAD3_MIN  = 8'hE0;
   localparam byte_type LEAD3_MAX  = 8'hEF;
   localparam byte_type LEAD4_MIN  = 8'hF0;
   localparam byte_type LEAD4_MAX  = 8'hF4;

   // Continuation byte pattern 10xxxxxx
   localparam logic [1:0] CONT_TAG = 2'b10;

   // Continuation counts per sequence length
   localparam count_type LEN_NONE = 2'd0;
   localparam count_type LEN_TWO  = 2'd1;
   localparam count_type LEN_THREE = 2'd2;
   localparam count_type LEN_FOUR = 2'd3;

   // Code point limits
   localparam cp_type CP_MIN_THREE = 21'h000800;
   localparam cp_type CP_MIN_FOUR  = 21'h010000;
   localparam cp_type SURR_LOW     = 21'h00D800;
   localparam cp_type SURR_HIGH    = 21'h00DFFF;
   localparam cp_type CP_MAX       = 21'h10FFFF;

endpackage

### rtl/core/utf8_stream_validator.sv
// UTF-8 stream validator: byte-wide input register, check logic and verdict register.
//
//   channel  dir  payload                               handshake
//   req_     in   tdata[7:0] data byte, tlast final     tvalid/tready
//   rsp_     out  tdata[0] string verdict, [7:1] zero   tvalid/tready
//
// One word is taken per cycle while no final word waits on a stalled verdict register.
// The decode of one word against the sequence state sits between the input
// register and the verdict register, so the state loop sets the rate of one word a cycle.
// Synchronous active-high reset clears the sequence state and both valid flags.
// A stalled verdict holds only a final word in the input register; other words flow on.
module utf8_stream_validator (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,   // last_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [0] string_valid, [7:1] zero
);
   import usv_pkg::*;

   `include "assert_macros.svh"

   logic      in_valid_ff, in_valid_in;
   byte_type  in_data_ff;
   logic      in_last_ff;

   count_type pend_ff, pend_in;
   count_type len_ff, len_in;
   cp_type    acc_ff, acc_in;
   logic      err_ff, err_in;

   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_verdict_ff;

   logic      out_free;
   logic      advance;
   cp_type    acc_shift;
   count_type pend_dec;
   logic      verdict;

   // Result register can take a verdict this cycle
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && (!in_last_ff || out_free);
   assign req_tready = !in_valid_ff || advance;

   assign in_valid_in  = req_tvalid ? 1'b1 : (in_valid_ff && !advance);
   assign rsp_valid_in = out_free ? (advance && in_last_ff) : rsp_valid_ff;

   // Decode the word against the current sequence state
   always_comb begin
      pend_in   = pend_ff;
      len_in    = len_ff;
      acc_in    = acc_ff;
      err_in    = err_ff;
      acc_shift = {acc_ff[CP_W-7:0], in_data_ff[5:0]};
      pend_dec  = pend_ff - 2'd1;
      if (!err_ff) begin
         if (pend_ff == LEN_NONE) begin
            if (in_data_ff == 8'h00) begin
               err_in = 1'b1;
            end else if (in_data_ff <= ASCII_MAX) begin
               err_in = 1'b0;
            end else if (in_data_ff >= LEAD2_MIN && in_data_ff <= LEAD2_MAX) begin
               acc_in  = {16'd0, in_data_ff[4:0]};
               pend_in = LEN_TWO;
               len_in  = LEN_TWO;
            end else if (in_data_ff >= LEAD3_MIN && in_data_ff <= LEAD3_MAX) begin
               acc_in  = {17'd0, in_data_ff[3:0]};
               pend_in = LEN_THREE;
               len_in  = LEN_THREE;
            end else if (in_data_ff >= LEAD4_MIN && in_data_ff <= LEAD4_MAX) begin
               acc_in  = {18'd0, in_data_ff[2:0]};
               pend_in = LEN_FOUR;
               len_in  = LEN_FOUR;
            end else begin
               err_in = 1'b1;
            end
         end else if (in_data_ff[7:6] != CONT_TAG) begin
            err_in = 1'b1;
         end else begin
            acc_in  = acc_shift;
            pend_in = pend_dec;
            // Range checks once the sequence completes
            if (pend_dec == LEN_NONE) begin
               if ((len_ff == LEN_THREE && acc_shift < CP_MIN_THREE) ||
                   (len_ff == LEN_FOUR && acc_shift < CP_MIN_FOUR) ||
                   (acc_shift >= SURR_LOW && acc_shift <= SURR_HIGH) ||
                   (acc_shift > CP_MAX)) begin
                  err_in = 1'b1;
               end
            end
         end
      end
   end

   assign verdict = !err_in && (pend_in == LEN_NONE);

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_tvalid && req_tready) begin
         in_data_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // Sequence state: advance per word, clear after the final word
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= LEN_NONE;
         len_ff  <= LEN_NONE;
         acc_ff  <= '0;
         err_ff  <= 1'b0;
      end else if (advance) begin
         if (in_last_ff) begin
            pend_ff <= LEN_NONE;
            len_ff  <= LEN_NONE;
            acc_ff  <= '0;
            err_ff  <= 1'b0;
         end else begin
            pend_ff <= pend_in;
            len_ff  <= len_in;
            acc_ff  <= acc_in;
            err_ff  <= err_in;
         end
      end
   end

   // Verdict register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (out_free && advance && in_last_ff) begin
         rsp_verdict_ff <= verdict;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_verdict_ff};

   // Checks
   `USV_ASSERT_IMP(a_pend_within_len, clock, reset,
      pend_ff != LEN_NONE, len_ff != LEN_NONE && pend_ff <= len_ff)
   `USV_ASSERT_NXT(a_state_clear_after_final, clock, reset,
      advance && in_last_ff, pend_ff == LEN_NONE && !err_ff && len_ff == LEN_NONE)
   `USV_ASSERT_NXT(a_final_waits_for_slot, clock, reset,
      in_valid_ff && in_last_ff && !out_free, in_valid_ff && in_last_ff)
   `USV_ASSERT_IMP(a_verdict_from_final, clock, reset,
      $rose(rsp_valid_ff), $past(advance && in_last_ff))

endmodule
